// ----- src/led_matrix_bitplane_scanner_macros.svh -----
// assertion macros shared by the checker of the led matrix bitplane scanner
// no dependencies
`ifndef LED_MATRIX_BITPLANE_SCANNER_MACROS_SVH
`define LED_MATRIX_BITPLANE_SCANNER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LMBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmbs assertion failed");

// antecedent implies consequent in the next cycle
`define LMBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmbs assertion failed");

`endif

// ----- src/lmbs_pkg.sv -----
// constants, gamma table and geometry helpers of the led matrix bitplane scanner
// no dependencies
package lmbs_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 128;
    localparam int PLANES      = 8;
    localparam int CHAINS      = 3;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int PIX_W   = 24;
    localparam int PLANE_W = 3;

    localparam logic       KIND_WRITE = 1'b0;
    localparam logic       KIND_SCAN  = 1'b1;

    localparam logic [1:0] CFG_ACTIVE_ROWS    = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_CHAIN_ENABLE   = 2'd2;
    localparam logic [1:0] CFG_BASE_TIME      = 2'd3;

    localparam logic [7:0] GAMMA [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,
        8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,
        8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,
        8'd16,8'd16,
        8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,8'd22,8'd22,8'd23,8'd24,
        8'd24,8'd25,
        8'd25,8'd26,8'd27,8'd27,8'd28,8'd29,8'd29,8'd30,8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,
        8'd35,8'd36,
        8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,
        8'd50,8'd50,
        8'd51,8'd52,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,
        8'd67,8'd68,
        8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,8'd85,8'd86,
        8'd87,8'd89,
        8'd90,8'd92,8'd93,8'd95,8'd96,8'd98,8'd99,8'd101,8'd102,8'd104,8'd105,8'd107,8'd109,
        8'd110,8'd112,8'd114,
        8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,8'd129,8'd131,8'd133,8'd135,
        8'd137,8'd138,8'd140,8'd142,
        8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,8'd160,8'd162,8'd164,8'd167,
        8'd169,8'd171,8'd173,8'd175,
        8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,8'd196,8'd198,8'd200,8'd203,
        8'd205,8'd208,8'd210,8'd213,
        8'd215,8'd218,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,8'd236,8'd239,8'd241,8'd244,
        8'd247,8'd249,8'd252,8'd255
    };

    function automatic logic [6:0] eff_rows(input logic [6:0] rows);
        logic [6:0] r;
        if (rows < 7'd2) begin
            r = 7'd2;
        end else if (rows > 7'(MAX_ROWS)) begin
            r = 7'(MAX_ROWS);
        end else begin
            r = rows;
        end
        return r;
    endfunction

    function automatic logic [7:0] eff_cols(input logic [7:0] cols);
        logic [7:0] c;
        if (cols == 8'd0) begin
            c = 8'd1;
        end else if (cols > 8'(MAX_COLUMNS)) begin
            c = 8'(MAX_COLUMNS);
        end else begin
            c = cols;
        end
        return c;
    endfunction

    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [4:0]         row_address;
        logic               last_in_row;
        logic               frame_end;
        logic [22:0]        on_time_ns;
    } scan_meta_t;

endpackage

// ----- src/lmbs_store.sv -----
// one chain of the pixel store: one write port, two registered read ports
// depends on lmbs_pkg
module lmbs_store (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [lmbs_pkg::ADDR_W-1:0] wr_addr,
    input  logic [lmbs_pkg::PIX_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [lmbs_pkg::ADDR_W-1:0] rd_addr_a,
    input  logic [lmbs_pkg::ADDR_W-1:0] rd_addr_b,
    output logic [lmbs_pkg::PIX_W-1:0]  rd_data_a,
    output logic [lmbs_pkg::PIX_W-1:0]  rd_data_b
);

    logic [lmbs_pkg::PIX_W-1:0] mem [lmbs_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- src/led_matrix_bitplane_scanner.sv -----
// led matrix bitplane scanner: pixel store with gamma, bcm scan word generator
// a scan word is read into the p1 stage, then its column word into the output register
// throughput: one word per cycle, pixel writes and scan words alike, unless m_tready stalls
// reset: scan restarts at the first word of a frame; after reset the pixel store
// is cleared, all 8192 addresses with s_tready low; config writes are taken throughout
// depends on lmbs_pkg and lmbs_store
module led_matrix_bitplane_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_row, pixel_column, chain_index, red, green, blue, zero pad
    input  logic [39:0] s_tdata,
    // kind
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chain0_bits, chain1_bits, chain2_bits, row_address, plane_index, on_time_ns, zero pad
    output logic [55:0] m_tdata,
    // last_in_row
    output logic        m_tlast,
    // frame_end
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = lmbs_pkg::ADDR_W;
    localparam int PW = lmbs_pkg::PIX_W;
    localparam int NC = lmbs_pkg::CHAINS;

    // configuration
    logic [6:0]  active_rows_reg, active_rows_next;
    logic [7:0]  active_columns_reg, active_columns_next;
    logic [2:0]  chain_enable_reg, chain_enable_next;
    logic [15:0] base_time_reg, base_time_next;

    // scan position
    logic [4:0]  row_reg, row_next;
    logic [2:0]  plane_reg, plane_next;
    logic [6:0]  col_reg, col_next;

    // clearing pass
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clear_addr_reg, clear_addr_next;

    // pipeline
    logic                    p1_valid_reg, p1_valid_next;
    lmbs_pkg::scan_meta_t    p1_meta_reg, p1_meta_next;
    logic                    m_valid_reg, m_valid_next;
    logic [55:0]             m_data_reg, m_data_next;
    logic                    m_last_reg, m_last_next;
    logic                    m_fend_reg, m_fend_next;

    logic [6:0] rows_eff;
    logic [5:0] half;
    logic [7:0] cols_eff;
    logic       in_acc, scan_acc, wr_acc, in_area, adv;
    logic [5:0] pix_row;
    logic [6:0] pix_col;
    logic [1:0] pix_chain;
    logic [PW-1:0] pix_gamma;
    logic [5:0] row_inc, lower_row;
    logic [6:0] rows_cfg;
    logic [5:0] half_cfg;
    logic [7:0] cols_cfg;

    logic [NC-1:0] wr_en;
    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [PW-1:0] wr_data;
    logic [PW-1:0] rd_a [NC];
    logic [PW-1:0] rd_b [NC];
    logic [5:0]    bits [NC];

    assign rows_eff  = lmbs_pkg::eff_rows(active_rows_reg);
    assign half      = rows_eff[6:1];
    assign cols_eff  = lmbs_pkg::eff_cols(active_columns_reg);

    assign pix_row   = s_tdata[5:0];
    assign pix_col   = s_tdata[12:6];
    assign pix_chain = s_tdata[14:13];
    assign pix_gamma = {lmbs_pkg::GAMMA[s_tdata[22:15]], lmbs_pkg::GAMMA[s_tdata[30:23]],
                        lmbs_pkg::GAMMA[s_tdata[38:31]]};

    assign adv      = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!p1_valid_reg || adv);
    assign in_acc   = s_tvalid && s_tready;
    assign scan_acc = in_acc && (s_tuser[0] == lmbs_pkg::KIND_SCAN);
    assign wr_acc   = in_acc && (s_tuser[0] == lmbs_pkg::KIND_WRITE);
    assign in_area  = ({1'b0, pix_row} < rows_eff) && ({1'b0, pix_col} < cols_eff)
                      && (pix_chain < 2'(NC));

    assign cfg_ready = 1'b1;

    assign row_inc   = {1'b0, row_reg} + 6'd1;
    assign lower_row = {1'b0, row_reg} + half;
    assign rd_addr_a = {1'b0, row_reg, col_reg};
    assign rd_addr_b = {lower_row, col_reg};
    assign wr_addr   = clearing_reg ? clear_addr_reg : {pix_row, pix_col};
    assign wr_data   = clearing_reg ? '0 : pix_gamma;

    for (genvar c = 0; c < NC; c++) begin : g_chain
        assign wr_en[c] = clearing_reg || (wr_acc && in_area && (pix_chain == 2'(c)));
        lmbs_store u_store (
            .aclk      (aclk),
            .wr_en     (wr_en[c]),
            .wr_addr   (wr_addr),
            .wr_data   (wr_data),
            .rd_en     (scan_acc),
            .rd_addr_a (rd_addr_a),
            .rd_addr_b (rd_addr_b),
            .rd_data_a (rd_a[c]),
            .rd_data_b (rd_b[c])
        );
        always_comb begin
            if (chain_enable_reg[c]) begin
                bits[c] = {rd_a[c][{2'd2, p1_meta_reg.plane}],
                           rd_a[c][{2'd1, p1_meta_reg.plane}],
                           rd_a[c][{2'd0, p1_meta_reg.plane}],
                           rd_b[c][{2'd2, p1_meta_reg.plane}],
                           rd_b[c][{2'd1, p1_meta_reg.plane}],
                           rd_b[c][{2'd0, p1_meta_reg.plane}]};
            end else begin
                bits[c] = '0;
            end
        end
    end

    always_comb begin
        active_rows_next    = active_rows_reg;
        active_columns_next = active_columns_reg;
        chain_enable_next   = chain_enable_reg;
        base_time_next      = base_time_reg;
        row_next            = row_reg;
        plane_next          = plane_reg;
        col_next            = col_reg;
        clearing_next       = clearing_reg;
        clear_addr_next     = clear_addr_reg;
        p1_valid_next       = p1_valid_reg;
        p1_meta_next        = p1_meta_reg;
        m_valid_next        = m_valid_reg;
        m_data_next         = m_data_reg;
        m_last_next         = m_last_reg;
        m_fend_next         = m_fend_reg;
        rows_cfg            = lmbs_pkg::eff_rows(cfg_data[6:0]);
        half_cfg            = rows_cfg[6:1];
        cols_cfg            = lmbs_pkg::eff_cols(cfg_data[7:0]);

        if (clearing_reg) begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == {AW{1'b1}}) begin
                clearing_next = 1'b0;
            end
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (adv) begin
            m_valid_next  = 1'b1;
            m_data_next   = {7'd0, p1_meta_reg.on_time_ns, p1_meta_reg.plane,
                             p1_meta_reg.row_address, bits[2], bits[1], bits[0]};
            m_last_next   = p1_meta_reg.last_in_row;
            m_fend_next   = p1_meta_reg.frame_end;
            p1_valid_next = 1'b0;
        end

        if (scan_acc) begin
            p1_valid_next            = 1'b1;
            p1_meta_next.plane       = plane_reg;
            p1_meta_next.row_address = (plane_reg != 3'd0) ? row_reg
                                     : ((row_inc == half) ? 5'd0 : row_inc[4:0]);
            p1_meta_next.last_in_row = (col_reg == 7'd0);
            p1_meta_next.frame_end   = (col_reg == 7'd0) && (row_reg == 5'd0)
                                       && (plane_reg == 3'(lmbs_pkg::PLANES - 1));
            p1_meta_next.on_time_ns  = {7'd0, base_time_reg} << plane_reg;
            if (col_reg != 7'd0) begin
                col_next = col_reg - 7'd1;
            end else begin
                col_next = 7'(cols_eff - 8'd1);
                if (plane_reg != 3'(lmbs_pkg::PLANES - 1)) begin
                    plane_next = plane_reg + 3'd1;
                end else begin
                    plane_next = 3'd0;
                    row_next   = (row_reg == 5'd0) ? 5'(half - 6'd1) : row_reg - 5'd1;
                end
            end
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lmbs_pkg::CFG_ACTIVE_ROWS: begin
                    active_rows_next = cfg_data[6:0];
                    row_next         = 5'(half_cfg - 6'd1);
                    plane_next       = 3'd0;
                    col_next         = 7'(cols_eff - 8'd1);
                end
                lmbs_pkg::CFG_ACTIVE_COLUMNS: begin
                    active_columns_next = cfg_data[7:0];
                    row_next            = 5'(half - 6'd1);
                    plane_next          = 3'd0;
                    col_next            = 7'(cols_cfg - 8'd1);
                end
                lmbs_pkg::CFG_CHAIN_ENABLE: begin
                    chain_enable_next = cfg_data[2:0];
                end
                lmbs_pkg::CFG_BASE_TIME: begin
                    base_time_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rows_reg    <= 7'd32;
            active_columns_reg <= 8'd64;
            chain_enable_reg   <= 3'd1;
            base_time_reg      <= 16'd100;
            row_reg            <= 5'd15;
            plane_reg          <= 3'd0;
            col_reg            <= 7'd63;
            clearing_reg       <= 1'b1;
            clear_addr_reg     <= '0;
            p1_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            active_rows_reg    <= active_rows_next;
            active_columns_reg <= active_columns_next;
            chain_enable_reg   <= chain_enable_next;
            base_time_reg      <= base_time_next;
            row_reg            <= row_next;
            plane_reg          <= plane_next;
            col_reg            <= col_next;
            clearing_reg       <= clearing_next;
            clear_addr_reg     <= clear_addr_next;
            p1_valid_reg       <= p1_valid_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_meta_reg <= p1_meta_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_fend_reg  <= m_fend_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_fend_reg;

endmodule

// ----- src/lmbs_checker.sv -----
// port-level checks of the led matrix bitplane scanner, bound to the top level
// depends on lmbs_pkg and led_matrix_bitplane_scanner_macros.svh
`include "led_matrix_bitplane_scanner_macros.svh"

module lmbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data
);

    logic scan_acc;
    assign scan_acc = s_tvalid && s_tready && (s_tuser[0] == lmbs_pkg::KIND_SCAN);

    `LMBS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LMBS_ASSERT_NOW(a_fend_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    `LMBS_ASSERT_NOW(a_word_from_scan, aclk, aresetn, $rose(m_tvalid), $past(scan_acc, 2))

endmodule

bind led_matrix_bitplane_scanner lmbs_checker u_lmbs_checker (.*);
